[rtl/core/eiht_pkg.sv]
// ----------------------------------------------------------------------------
// EtherIP header translator package
// Shared types and constants for the translator core.
// ----------------------------------------------------------------------------
package eiht_pkg;

  localparam logic [15:0] EtypeIpv6    = 16'h86dd;
  localparam logic [7:0]  NhEtherip    = 8'd97;
  localparam logic [10:0] MinLen       = 11'd56;
  localparam logic [10:0] KeepaliveLen = 11'd60;
  localparam logic [15:0] RewriteHdr   = 16'h3000;

  localparam logic [1:0] ActFwd     = 2'd0;
  localparam logic [1:0] ActRewrite = 2'd1;
  localparam logic [1:0] ActReflect = 2'd2;
  localparam logic [1:0] ActDrop    = 2'd3;

  localparam logic [1:0] ClsPass     = 2'd0;
  localparam logic [1:0] ClsOutKeep  = 2'd1;
  localparam logic [1:0] ClsOutRw    = 2'd2;
  localparam logic [1:0] ClsIn       = 2'd3;

  typedef struct packed {
    logic        op;
    logic [10:0] frame_len;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [15:0] ethertype;
    logic [7:0]  nxt_hdr;
    logic [63:0] src_ip_hi;
    logic [63:0] src_ip_lo;
    logic [63:0] dst_ip_hi;
    logic [63:0] dst_ip_lo;
    logic [15:0] etherip_hdr;
    logic [31:0] trailer_word;
  } hdr_in_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [47:0] out_dst_mac;
    logic [47:0] out_src_mac;
    logic [63:0] out_src_ip_hi;
    logic [63:0] out_src_ip_lo;
    logic [63:0] out_dst_ip_hi;
    logic [63:0] out_dst_ip_lo;
    logic [15:0] out_etherip_hdr;
    logic        table_full;
  } hdr_out_t;

  typedef struct packed {
    logic [1:0]  cls;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [63:0] src_ip_hi;
    logic [63:0] src_ip_lo;
    logic [63:0] dst_ip_hi;
    logic [63:0] dst_ip_lo;
    logic [15:0] etherip_hdr;
  } job_t;

endpackage

[rtl/core/etherip_header_translator_core.sv]
// ----------------------------------------------------------------------------
// EtherIP header translator core
// Classifies frame headers, keeps the tunnel address table, emits one result.
// ----------------------------------------------------------------------------
// In the back end the time per header is set by the table scan, which reads
// one entry per cycle; frames that are not EtherIP leave the scan at once.
// A two-entry queue lets start be taken while the back end works; busy rises
// when the queue is full. Results appear on res_o with done_o high for a
// single cycle, and they cannot be stalled.
module etherip_header_translator_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  eiht_pkg::hdr_in_t  hdr_i,
  output logic               busy,
  output logic               done_o,
  output eiht_pkg::hdr_out_t res_o
);
  import eiht_pkg::*;

  logic job_valid, job_pop;
  job_t job;

  eiht_front u_front (
    .clk_i, .rst_ni, .start_i(start), .hdr_i, .busy_o(busy),
    .job_valid_o(job_valid), .job_o(job), .job_pop_i(job_pop)
  );

  eiht_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_i(job),
    .job_pop_o(job_pop), .done_o, .res_o
  );
endmodule

[rtl/core/eiht_front.sv]
// ----------------------------------------------------------------------------
// EtherIP translator front end
// Classifies each accepted header and pushes a job into a two-entry queue.
// ----------------------------------------------------------------------------
module eiht_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  eiht_pkg::hdr_in_t hdr_i,
  output logic             busy_o,
  output logic             job_valid_o,
  output eiht_pkg::job_t   job_o,
  input  logic             job_pop_i
);
  import eiht_pkg::*;

  job_t       q_mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  job_t       job_new;
  logic       is_eip, keep;

  assign busy_o      = (cnt_q == 2'd2);
  assign push        = start_i && !busy_o;
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    is_eip = (hdr_i.frame_len >= MinLen) && (hdr_i.ethertype == EtypeIpv6)
          && (hdr_i.nxt_hdr == NhEtherip);
    keep = (hdr_i.frame_len < KeepaliveLen)
        || ((hdr_i.frame_len == KeepaliveLen) && (hdr_i.trailer_word == 32'd0));
    job_new.dst_mac     = hdr_i.dst_mac;
    job_new.src_mac     = hdr_i.src_mac;
    job_new.src_ip_hi   = hdr_i.src_ip_hi;
    job_new.src_ip_lo   = hdr_i.src_ip_lo;
    job_new.dst_ip_hi   = hdr_i.dst_ip_hi;
    job_new.dst_ip_lo   = hdr_i.dst_ip_lo;
    job_new.etherip_hdr = hdr_i.etherip_hdr;
    priority if (!is_eip) job_new.cls = ClsPass;
    else if (hdr_i.op)    job_new.cls = ClsIn;
    else if (keep)        job_new.cls = ClsOutKeep;
    else                  job_new.cls = ClsOutRw;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, job_pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wr_ptr_q] <= job_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (job_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_i |-> job_valid_o) else $error("pop from empty queue");
  a_full_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !push) else $error("push into full queue");
endmodule

[rtl/core/eiht_back.sv]
// ----------------------------------------------------------------------------
// EtherIP translator back end
// Scans the address table one entry per cycle, updates it and emits results.
// ----------------------------------------------------------------------------
module eiht_back #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  eiht_pkg::job_t    job_i,
  output logic              job_pop_o,
  output logic              done_o,
  output eiht_pkg::hdr_out_t res_o
);
  import eiht_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [127:0]  addr_mem [TABLE_DEPTH];
  logic [15:0]   hdr_mem  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [CW-1:0] fill_q;
  logic [1:0]    st_q;
  logic [CW-1:0] idx_q;
  logic [IW-1:0] idx_a;
  job_t          job_q;
  logic          hit_q;
  logic [IW-1:0] hit_idx_q;
  logic [127:0]  rd_addr_q;
  logic [15:0]   rd_hdr_q;
  logic          rd_valid_q;
  logic [127:0]  key;
  logic          match;
  logic          last;
  hdr_out_t      res_q, res_d;
  logic          done_q;
  logic          full;
  logic [15:0]   hit_hdr_q;

  assign idx_a = idx_q[IW-1:0];
  assign key   = (job_q.cls == ClsIn) ? {job_q.src_ip_hi, job_q.src_ip_lo}
                                      : {job_q.dst_ip_hi, job_q.dst_ip_lo};
  assign match = rd_valid_q && (rd_addr_q == key);
  assign last  = (idx_q == DepthC);
  assign job_pop_o = (st_q == StIdle) && job_valid_i;
  assign done_o = done_q;
  assign res_o  = res_q;
  assign full   = !hit_q && (fill_q == DepthC);

  always_comb begin
    res_d.action          = ActFwd;
    res_d.out_dst_mac     = job_q.dst_mac;
    res_d.out_src_mac     = job_q.src_mac;
    res_d.out_src_ip_hi   = job_q.src_ip_hi;
    res_d.out_src_ip_lo   = job_q.src_ip_lo;
    res_d.out_dst_ip_hi   = job_q.dst_ip_hi;
    res_d.out_dst_ip_lo   = job_q.dst_ip_lo;
    res_d.out_etherip_hdr = job_q.etherip_hdr;
    res_d.table_full      = 1'b0;
    unique case (job_q.cls)
      ClsPass: res_d.action = ActFwd;
      ClsIn: begin
        res_d.action = hit_q ? ActRewrite : ActDrop;
        if (hit_q) res_d.out_etherip_hdr = hit_hdr_q;
      end
      ClsOutKeep: begin
        res_d.action        = ActReflect;
        res_d.table_full    = full;
        res_d.out_dst_mac   = job_q.src_mac;
        res_d.out_src_mac   = job_q.dst_mac;
        res_d.out_src_ip_hi = job_q.dst_ip_hi;
        res_d.out_src_ip_lo = job_q.dst_ip_lo;
        res_d.out_dst_ip_hi = job_q.src_ip_hi;
        res_d.out_dst_ip_lo = job_q.src_ip_lo;
      end
      default: begin
        res_d.action          = ActRewrite;
        res_d.table_full      = full;
        res_d.out_etherip_hdr = RewriteHdr;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StScan && !last) begin
      rd_addr_q <= addr_mem[idx_a];
      rd_hdr_q  <= hdr_mem[idx_a];
    end
    if (job_pop_o) job_q <= job_i;
    if (st_q == StScan && match && !hit_q) begin
      hit_idx_q <= idx_q[IW-1:0] - IW'(1);
      hit_hdr_q <= rd_hdr_q;
    end
    if (st_q == StDone && job_q.cls != ClsIn && job_q.cls != ClsPass) begin
      if (hit_q) hdr_mem[hit_idx_q] <= job_q.etherip_hdr;
      else if (!full) begin
        hdr_mem[fill_q[IW-1:0]]  <= job_q.etherip_hdr;
        addr_mem[fill_q[IW-1:0]] <= key;
      end
    end
    if (st_q == StDone) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= StIdle;
      valid_q    <= '0;
      fill_q     <= '0;
      idx_q      <= '0;
      hit_q      <= 1'b0;
      rd_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      done_q <= (st_q == StDone);
      unique case (st_q)
        StIdle: begin
          if (job_pop_o) begin
            st_q       <= StScan;
            idx_q      <= '0;
            hit_q      <= 1'b0;
            rd_valid_q <= 1'b0;
          end
        end
        StScan: begin
          rd_valid_q <= !last && valid_q[idx_a];
          if (match) hit_q <= 1'b1;
          if (last || job_q.cls == ClsPass) st_q <= StDone;
          else idx_q <= idx_q + CW'(1);
        end
        StDone: begin
          st_q <= StIdle;
          if (job_q.cls == ClsOutKeep || job_q.cls == ClsOutRw) begin
            if (!hit_q && !full) begin
              valid_q[fill_q[IW-1:0]] <= 1'b1;
              fill_q <= fill_q + CW'(1);
            end
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= DepthC) else $error("fill count past depth");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("result strobe held");
  a_scan_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StScan) |-> (idx_q <= DepthC)) else $error("scan index out of range");
endmodule
